@@ rtl/core/refcounted_frame_allocator_top_defines.svh @@
// Assertion macros shared by the frame allocator RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef REFCOUNTED_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rfa_pkg.sv @@
// Package for the frame allocator: request/result types, op and status codes,
// sizes and the bit-search helper. No dependencies.
package rfa_pkg;

    localparam int MAX_FRAMES  = 32768;
    localparam int FRAME_SHIFT = 12;
    localparam int FRAME_AW    = $clog2(MAX_FRAMES);
    localparam int MAP_AW      = FRAME_AW - 5;
    localparam int SUM_AW      = MAP_AW - 5;
    localparam int TOTAL_W     = FRAME_AW + 1;
    localparam int FNUM_W      = 32 - FRAME_SHIFT;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_REF   = 3'd2;
    localparam logic [2:0] OP_UNREF = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] phys_address;
    } req_t;

    typedef struct packed {
        logic [31:0] frame_address;
        logic [15:0] ref_count;
        logic [1:0]  status;
        logic [15:0] free_count;
    } rsp_t;

    // Index of the lowest set bit; 0 when none is set.
    function automatic logic [4:0] lowest_set(input logic [31:0] w);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/refcounted_frame_allocator_top.sv @@
// Top level of the reference-counted frame allocator.
// Depends on rfa_pkg, rfa_ram and refcounted_frame_allocator_top_defines.svh.

// Frame allocator for 32768 frames of 4 KiB. A request is taken when start is
// high and busy is low; its result appears on rsp for one cycle with done high
// and must be taken then, as the receiver cannot stall. Free, ref, unref and
// query pass S_RD, S_OP; alloc passes S_RD, S_A2, S_A3; invalid frames, unused
// op codes and alloc with nothing free end in S_RD; the next request may be
// accepted in the cycle done is high. State lives in three RAMs: the per-frame
// count, the used bitmap in 32-bit words, and a summary with one bit per
// bitmap word that still holds a free frame; a 32-bit register marks summary
// words that are not empty. Alloc walks register, summary and bitmap, one RAM
// read each. After reset a clearing pass over all frames sets every count to
// one and every frame used; busy stays high during it. frame_total lies at
// APB address 0 and may be written at any time the block is idle.
module refcounted_frame_allocator_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rfa_pkg::req_t req,
    output logic          done,
    output rfa_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import rfa_pkg::*;
    `include "refcounted_frame_allocator_top_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_A2   = 3'd2;
    localparam logic [2:0] S_A3   = 3'd3;
    localparam logic [2:0] S_OP   = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [FRAME_AW-1:0] clr_reg, clr_next;
    logic [15:0]         total_reg;
    logic [15:0]         free_reg, free_next;
    logic [31:0]         top_reg, top_next;
    logic [2:0]          op_reg;
    logic [FNUM_W-1:0]   fnum_reg;
    logic [4:0]          sidx_reg, sidx_next;
    logic [4:0]          jidx_reg, jidx_next;
    logic [31:0]         sword_reg, sword_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    // RAM ports
    logic                cnt_we, map_we, sum_we;
    logic [FRAME_AW-1:0] cnt_waddr, cnt_raddr;
    logic [MAP_AW-1:0]   map_waddr, map_raddr;
    logic [SUM_AW-1:0]   sum_waddr, sum_raddr;
    logic [15:0]         cnt_wdata, cnt_rdata;
    logic [31:0]         map_wdata, map_rdata, sum_wdata, sum_rdata;

    rfa_ram #(.DW(16), .AW(FRAME_AW)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    rfa_ram #(.DW(32), .AW(MAP_AW)) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );
    rfa_ram #(.DW(32), .AW(SUM_AW)) u_sum (
        .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    // Configuration: a single register, so every address decodes to it.
    assign pready = 1'b1;
    assign prdata = {16'd0, total_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 16'd32768;
        end
        else if (psel && penable && pwrite)
        begin
            total_reg <= pwdata[15:0];
        end
    end

    // Effective total: clip the register at the frame capacity.
    logic [TOTAL_W-1:0] eff_total;
    assign eff_total = ({1'b0, total_reg} < 17'(MAX_FRAMES)) ?
                       TOTAL_W'(total_reg) : TOTAL_W'(MAX_FRAMES);

    logic                accept;
    logic                fr_valid;
    logic [FRAME_AW-1:0] fr;
    logic [4:0]          bit_f;
    logic [4:0]          j_f;
    logic [4:0]          b_alloc;
    logic [FRAME_AW-1:0] f_alloc;
    logic [31:0]         map_set, map_clr, sum_after_set;
    logic [15:0]         free_inc, free_dec;

    assign accept   = start && !busy;
    assign fr       = fnum_reg[FRAME_AW-1:0];
    assign bit_f    = fr[4:0];
    assign j_f      = fr[9:5];
    assign fr_valid = 32'(fnum_reg) < 32'(eff_total);
    assign b_alloc  = lowest_set(~map_rdata);
    assign f_alloc  = {sidx_reg, jidx_reg, b_alloc};
    assign map_set  = map_rdata | (32'd1 << b_alloc);
    assign map_clr  = map_rdata & ~(32'd1 << bit_f);
    assign sum_after_set = sum_rdata | (32'd1 << j_f);
    assign free_inc = (free_reg != 16'hFFFF) ? free_reg + 16'd1 : free_reg;
    assign free_dec = (free_reg != 16'd0) ? free_reg - 16'd1 : free_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        free_next  = free_reg;
        top_next   = top_reg;
        sidx_next  = sidx_reg;
        jidx_next  = jidx_reg;
        sword_next = sword_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        cnt_we = 1'b0; cnt_waddr = fr;              cnt_wdata = 16'd0;
        map_we = 1'b0; map_waddr = fr[FRAME_AW-1:5]; map_wdata = map_clr;
        sum_we = 1'b0; sum_waddr = fr[FRAME_AW-1:10]; sum_wdata = sum_after_set;

        cnt_raddr = fr;
        map_raddr = fr[FRAME_AW-1:5];
        sum_raddr = fr[FRAME_AW-1:10];

        unique case (state_reg)
            S_CLR:
            begin
                // Clear pass: every count one, every frame used, summaries empty.
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = 16'd1;
                map_we    = (clr_reg >> MAP_AW) == '0;
                map_waddr = clr_reg[MAP_AW-1:0];
                map_wdata = '1;
                sum_we    = (clr_reg >> SUM_AW) == '0;
                sum_waddr = clr_reg[SUM_AW-1:0];
                sum_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                rsp_next.frame_address = 32'd0;
                rsp_next.ref_count     = 16'd0;
                rsp_next.free_count    = free_reg;
                if (op_reg == OP_ALLOC)
                begin
                    sidx_next = lowest_set(top_reg);
                    sum_raddr = lowest_set(top_reg);
                    if (top_reg == 32'd0)
                    begin
                        rsp_next.status = ST_NOFREE;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_A2;
                    end
                end
                else if (op_reg > OP_QUERY || !fr_valid)
                begin
                    rsp_next.status = ST_IGNORED;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_OP;
                end
            end
            S_A2:
            begin
                // Hold the summary word; fetch the bitmap word it points to.
                sword_next = sum_rdata;
                jidx_next  = lowest_set(sum_rdata);
                map_raddr  = {sidx_reg, lowest_set(sum_rdata)};
                state_next = S_A3;
            end
            S_A3:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (32'(f_alloc) < 32'(eff_total))
                begin
                    map_we    = 1'b1;
                    map_waddr = {sidx_reg, jidx_reg};
                    map_wdata = map_set;
                    cnt_we    = 1'b1;
                    cnt_waddr = f_alloc;
                    cnt_wdata = 16'd1;
                    if (map_set == '1)
                    begin
                        sum_we    = 1'b1;
                        sum_waddr = sidx_reg;
                        sum_wdata = sword_reg & ~(32'd1 << jidx_reg);
                        if ((sword_reg & ~(32'd1 << jidx_reg)) == 32'd0)
                        begin
                            top_next = top_reg & ~(32'd1 << sidx_reg);
                        end
                    end
                    free_next              = free_dec;
                    rsp_next.frame_address = {{(32 - FRAME_AW - FRAME_SHIFT){1'b0}},
                                              f_alloc, {FRAME_SHIFT{1'b0}}};
                    rsp_next.status        = ST_DONE;
                    rsp_next.free_count    = free_dec;
                end
                else
                begin
                    rsp_next.status = ST_NOFREE;
                end
            end
            S_OP:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (!map_rdata[bit_f])
                begin
                    rsp_next.status = ST_IGNORED;
                end
                else
                begin
                    rsp_next.status = ST_DONE;
                    case (op_reg)
                        OP_REF:
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = (cnt_rdata != COUNT_MAX) ? cnt_rdata + 16'd1
                                                                 : cnt_rdata;
                        end
                        OP_QUERY:
                        begin
                            rsp_next.ref_count = cnt_rdata;
                        end
                        default:
                        begin
                            // Free: release the frame; unref: drop a reference, release at one or below.
                            cnt_we = 1'b1;
                            if (op_reg == OP_UNREF && cnt_rdata > 16'd1)
                            begin
                                cnt_wdata = cnt_rdata - 16'd1;
                            end
                            else
                            begin
                                cnt_wdata           = 16'd0;
                                map_we              = 1'b1;
                                sum_we              = 1'b1;
                                top_next            = top_reg | (32'd1 << fr[14:10]);
                                free_next           = free_inc;
                                rsp_next.free_count = free_inc;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            free_reg  <= 16'd0;
            top_reg   <= 32'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            free_reg  <= free_next;
            top_reg   <= top_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.op;
            fnum_reg <= req.phys_address[31:FRAME_SHIFT];
        end
        sidx_reg  <= sidx_next;
        jidx_reg  <= jidx_next;
        sword_reg <= sword_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `RFA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
    `RFA_ASSERT_NOW(a_done_after_work, done, $past(busy), "result without a request")
    `RFA_ASSERT_NOW(a_free_bound, 1'b1, free_reg <= 16'(MAX_FRAMES),
                    "free count above capacity")
    `RFA_ASSERT_NEXT(a_alloc_top, state_reg == S_RD && op_reg == OP_ALLOC && top_reg != 0,
                     state_reg == S_A2, "alloc with free frames skipped the search")
endmodule

@@ rtl/core/rfa_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rfa_ram #(
    parameter int DW = 16,
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
